@@ rtl/nmea_sentence_checker_defines.svh @@
// ----------------------------------------------------------------------------
// NMEA sentence checker assertion macros
// Concurrent assertion forms used by the checker's back end.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMEA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nmea: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NMEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nmea: next-cycle check failed");

`endif

@@ rtl/nmea_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Types and constants shared by the front end, queue, back end and top level.
// ----------------------------------------------------------------------------
package nmea_pkg;

    localparam int ID_COUNT    = 7;
    localparam int ID_W        = 40;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [2:0] TYPE_NONE = 3'd7;

    typedef logic [ID_W-1:0] id_word_t;
    typedef id_word_t [ID_COUNT-1:0] id_table_t;

    // Index 0 sits in the lowest slot: GPRMC, GPVTG, GPGGA, GPGSA, GPGSV, GPGLL, GPTXT.
    localparam id_table_t ID_RESET = {
        40'h4750545854, 40'h4750474C4C, 40'h4750475356, 40'h4750475341,
        40'h4750474741, 40'h4750565447, 40'h4750524D43
    };

    // One received byte with its classification.
    typedef struct packed {
        logic [7:0] data;
        logic       is_start;
        logic       is_star;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] hex_digit;
    } nmea_item_t;

    // One checked sentence.
    typedef struct packed {
        logic       sentence_valid;
        logic       framing_ok;
        logic       length_overflow;
        logic [2:0] sentence_type;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } nmea_result_t;

endpackage

@@ rtl/nmea_front.sv @@
// ----------------------------------------------------------------------------
// NMEA front end
// Classifies each received byte (framing characters and hex digit value).
// ----------------------------------------------------------------------------
module nmea_front (
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    output logic                item_valid,
    output nmea_pkg::nmea_item_t item,
    input  logic                item_ready
);

    logic [7:0] ch;

    assign ch         = in_byte;
    assign item_valid = in_valid;
    assign in_ready   = item_ready;

    always_comb begin
        item           = '0;
        item.data      = ch;
        item.is_start  = (ch == nmea_pkg::CH_START);
        item.is_star   = (ch == nmea_pkg::CH_STAR);
        item.is_cr     = (ch == nmea_pkg::CH_CR);
        item.is_lf     = (ch == nmea_pkg::CH_LF);
        if (ch >= 8'h30 && ch <= 8'h39) begin
            item.is_hex    = 1'b1;
            item.hex_digit = ch[3:0];
        end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            // Letters A-F and a-f share the low three bits; add nine to get 10..15.
            item.is_hex    = 1'b1;
            item.hex_digit = 4'(ch[2:0] + 3'd0) + 4'd9;
        end
    end

endmodule

@@ rtl/nmea_queue.sv @@
// ----------------------------------------------------------------------------
// NMEA item queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module nmea_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  nmea_pkg::nmea_item_t push_item,
    output logic                 push_ready,
    output logic                 pop_valid,
    output nmea_pkg::nmea_item_t pop_item,
    input  logic                 pop_ready
);

    nmea_pkg::nmea_item_t             q_mem_reg [nmea_pkg::QUEUE_DEPTH];
    logic [nmea_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nmea_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nmea_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        push, pop;

    assign push_ready = (count_reg != (nmea_pkg::QPTR_W+1)'(nmea_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = q_mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/nmea_back.sv @@
// ----------------------------------------------------------------------------
// NMEA back end
// Sentence state update, ID match and the registered result output.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checker_defines.svh"

module nmea_back #(
    parameter int MAX_LEN = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  nmea_pkg::nmea_item_t   item,
    output logic                   item_ready,
    input  nmea_pkg::id_table_t    id_words,
    output logic                   res_valid,
    output nmea_pkg::nmea_result_t res,
    input  logic                   res_ready
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic             start_seen_reg, start_seen_next;
    logic             star_seen_reg, star_seen_next;
    logic [7:0]       xor_reg, xor_next;
    logic [1:0]       hex_cnt_reg, hex_cnt_next;
    logic [7:0]       hex_val_reg, hex_val_next;
    logic             hex_stop_reg, hex_stop_next;
    logic [39:0]      id_shift_reg, id_shift_next;
    logic [2:0]       id_cnt_reg, id_cnt_next;
    logic             prev_cr_reg, prev_cr_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             ovf_reg, ovf_next;

    logic                   res_valid_reg, res_valid_next;
    nmea_pkg::nmea_result_t res_reg, res_next;

    logic ends_sentence, out_free, pop, clear;
    logic framing;
    logic [2:0] type_sel;

    assign ends_sentence = item.is_lf && prev_cr_reg;
    assign out_free      = !res_valid_reg || res_ready;
    assign item_ready    = !ends_sentence || out_free;
    assign pop           = item_valid && item_ready;
    assign clear         = item.is_start || ends_sentence;
    assign res_valid     = res_valid_reg;
    assign res           = res_reg;

    // First matching ID wins; the descending scan leaves the lowest index.
    always_comb begin
        type_sel = nmea_pkg::TYPE_NONE;
        for (int i = nmea_pkg::ID_COUNT - 1; i >= 0; i--) begin
            if (id_words[i] == id_shift_reg) begin
                type_sel = 3'(i);
            end
        end
    end

    assign framing = start_seen_reg && star_seen_reg;

    always_comb begin
        res_next                 = res_reg;
        res_next.sentence_valid  = framing && (xor_reg == hex_val_reg) && !ovf_reg;
        res_next.framing_ok      = framing;
        res_next.length_overflow = ovf_reg;
        res_next.sentence_type   = type_sel;
        res_next.computed_sum    = xor_reg;
        res_next.received_sum    = hex_val_reg;
        res_valid_next           = res_valid_reg && !res_ready;
        if (pop && ends_sentence) begin
            res_valid_next = 1'b1;
        end
    end

    // Sentence state: optional clear, then the byte is stored and scanned, or overflow is set if the buffer is full.
    always_comb begin
        start_seen_next = clear ? 1'b0 : start_seen_reg;
        star_seen_next  = clear ? 1'b0 : star_seen_reg;
        xor_next        = clear ? 8'd0 : xor_reg;
        hex_cnt_next    = clear ? 2'd0 : hex_cnt_reg;
        hex_val_next    = clear ? 8'd0 : hex_val_reg;
        hex_stop_next   = clear ? 1'b0 : hex_stop_reg;
        id_shift_next   = clear ? 40'd0 : id_shift_reg;
        id_cnt_next     = clear ? 3'd0 : id_cnt_reg;
        byte_cnt_next   = clear ? '0 : byte_cnt_reg;
        ovf_next        = clear ? 1'b0 : ovf_reg;
        prev_cr_next    = item.is_cr;

        if (byte_cnt_next >= CNT_W'(MAX_LEN)) begin
            ovf_next = 1'b1;
        end else begin
            byte_cnt_next = byte_cnt_next + 1'b1;
            if (star_seen_next && hex_cnt_next != 2'd2) begin
                if (!hex_stop_next) begin
                    if (item.is_hex) begin
                        hex_val_next = {hex_val_next[3:0], item.hex_digit};
                    end else begin
                        hex_stop_next = 1'b1;
                    end
                end
                hex_cnt_next = hex_cnt_next + 1'b1;
            end
            if (start_seen_next && id_cnt_next < 3'd5) begin
                case (id_cnt_next)
                    3'd0:    id_shift_next[39:32] = item.data;
                    3'd1:    id_shift_next[31:24] = item.data;
                    3'd2:    id_shift_next[23:16] = item.data;
                    3'd3:    id_shift_next[15:8]  = item.data;
                    3'd4:    id_shift_next[7:0]   = item.data;
                    default: id_shift_next        = id_shift_next;
                endcase
                id_cnt_next = id_cnt_next + 1'b1;
            end
            if (start_seen_next && !star_seen_next && !item.is_star) begin
                xor_next = xor_next ^ item.data;
            end
            if (item.is_star) begin
                star_seen_next = 1'b1;
            end
            if (item.is_start) begin
                start_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seen_reg <= 1'b0;
            star_seen_reg  <= 1'b0;
            xor_reg        <= '0;
            hex_cnt_reg    <= '0;
            hex_val_reg    <= '0;
            hex_stop_reg   <= 1'b0;
            id_shift_reg   <= '0;
            id_cnt_reg     <= '0;
            prev_cr_reg    <= 1'b0;
            byte_cnt_reg   <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                start_seen_reg <= start_seen_next;
                star_seen_reg  <= star_seen_next;
                xor_reg        <= xor_next;
                hex_cnt_reg    <= hex_cnt_next;
                hex_val_reg    <= hex_val_next;
                hex_stop_reg   <= hex_stop_next;
                id_shift_reg   <= id_shift_next;
                id_cnt_reg     <= id_cnt_next;
                prev_cr_reg    <= prev_cr_next;
                byte_cnt_reg   <= byte_cnt_next;
                ovf_reg        <= ovf_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && ends_sentence) begin
            res_reg <= res_next;
        end
    end

    `NMEA_ASSERT_NEXT(a_state_cleared_after_end, pop && ends_sentence, byte_cnt_reg == CNT_W'(1) && !start_seen_reg && !ovf_reg && res_valid_reg)
    `NMEA_ASSERT_NEXT(a_start_opens_sentence, pop && item.is_start, start_seen_reg && !star_seen_reg && byte_cnt_reg == CNT_W'(1))
    `NMEA_ASSERT_NOW(a_valid_needs_framing, res_valid_reg && res_reg.sentence_valid, res_reg.framing_ok && !res_reg.length_overflow)

endmodule

@@ rtl/nmea_sentence_checker.sv @@
// A terminating LF passes through the queue memory and then the result register,
// whose valid bit drives m_tvalid.
// Throughput: one byte per cycle; a byte that ends a sentence waits only if the
// result register is still held by a stalled consumer (four-item queue in between).
// Reset (aresetn low, synchronous): ID table returns to its defaults, the
// sentence state and queue are cleared and no result is pending.
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checksum and sentence ID check of a received NMEA 0183 byte stream.
// ----------------------------------------------------------------------------
//
// The front end classifies each byte ('$', '*', CR, LF, hex digit value) and
// pushes it into a four-item queue. The back end pops one item per cycle
// unless an LF ending a sentence waits on a held result, updates the sentence
// state and, on a LF after a CR, loads one result into the output register.
// The queue lets the input side keep taking bytes while a result waits for the consumer.
//
// A '$' restarts the sentence. The checksum is the XOR of the bytes after '$'
// up to the first '*', compared with up to two hex digits after the '*'. The
// five bytes after '$' are matched against seven ID registers, first match
// wins, type seven meaning no match. A byte arriving after MAX_LEN stored bytes
// marks the sentence as overflowed and invalid.
//
// The ID registers are written through the cfg channel, always ready; index seven
// is ignored. The user writes them only while the block is idle; it does not check.
module nmea_sentence_checker #(
    parameter int MAX_LEN = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [0] sentence_valid, [1] framing_ok,
                                     // [2] length_overflow, [10:3] computed_sum,
                                     // [18:11] received_sum, [23:19] zero
    output logic [2:0]  m_tuser,     // [2:0] sentence_type

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    nmea_pkg::id_table_t    id_table_reg;
    nmea_pkg::nmea_item_t   front_item, queue_item;
    nmea_pkg::nmea_result_t result;
    logic                   front_valid, front_ready;
    logic                   queue_valid, queue_ready;

    // ID register file; the user writes it only while no sentence is in flight (not checked).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_table_reg <= nmea_pkg::ID_RESET;
        end else if (cfg_valid && cfg_index < 3'(nmea_pkg::ID_COUNT)) begin
            id_table_reg[cfg_index] <= cfg_data;
        end
    end

    nmea_front u_front (
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_ready   (s_tready),
        .item_valid (front_valid),
        .item       (front_item),
        .item_ready (front_ready)
    );

    nmea_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_item  (front_item),
        .push_ready (front_ready),
        .pop_valid  (queue_valid),
        .pop_item   (queue_item),
        .pop_ready  (queue_ready)
    );

    nmea_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_ready (queue_ready),
        .id_words   (id_table_reg),
        .res_valid  (m_tvalid),
        .res        (result),
        .res_ready  (m_tready)
    );

    // Pack the result flags and sums; the ID match index travels in tuser.
    assign m_tdata = {5'd0, result.received_sum, result.computed_sum,
                      result.length_overflow, result.framing_ok, result.sentence_valid};
    assign m_tuser = result.sentence_type;

endmodule

@@ tb/sv/tb_nmea_sentence_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Feeds a byte stream of well-formed, broken and noisy NMEA sentences,
// rewrites the ID table between phases and checks every sentence result
// against a cycle-free model of the checksum and ID logic.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_checker;

    import nmea_pkg::*;

    // Buffer length of the block; sentences near this size exercise overflow.
    localparam int SENTENCE_MAX  = 256;
    // Cycles allowed after the last result before the ID table is touched
    // or the run is closed; covers the front end, the queue and the output.
    localparam int SETTLE_CYCLES = 16;
    // Index past the ID table; writes to it must be ignored.
    localparam logic [2:0] REG_UNUSED = 3'(ID_COUNT);

    // ------------------------------------------------------------------------
    // Sentence model: tracks the sentence state byte by byte, queues the
    // result that each terminating LF should produce and checks the block's
    // results against that queue in order.
    // ------------------------------------------------------------------------
    class sentence_scoreboard;
        id_table_t      id_table;
        logic           start_seen;
        logic           star_seen;
        logic           hex_stopped;
        logic           last_was_cr;
        logic           overflowed;
        logic [7:0]     xor_sum;
        logic [7:0]     hex_sum;
        logic [ID_W-1:0] id_bytes;
        int unsigned    hex_count;
        int unsigned    id_count;
        int unsigned    stored_count;
        int unsigned    buffer_len;
        int unsigned    mismatches;
        nmea_result_t   pending[$];

        function new(int unsigned max_len);
            buffer_len = max_len;
            mismatches = 0;
            id_table   = ID_RESET;
            clear_sentence();
        endfunction

        function void clear_sentence();
            start_seen   = 1'b0;
            star_seen    = 1'b0;
            hex_stopped  = 1'b0;
            last_was_cr  = 1'b0;
            overflowed   = 1'b0;
            xor_sum      = '0;
            hex_sum      = '0;
            id_bytes     = '0;
            hex_count    = 0;
            id_count     = 0;
            stored_count = 0;
        endfunction

        function void set_id_word(logic [2:0] index, logic [ID_W-1:0] word);
            if (index < ID_COUNT) begin
                id_table[index] = word;
            end
        endfunction

        // Called for every byte the block accepts.
        function void note_byte(logic [7:0] b);
            nmea_result_t sentence;
            int           digit;
            if (b == CH_START) begin
                clear_sentence();
            end else if (b == CH_LF && last_was_cr) begin
                sentence.framing_ok      = start_seen && star_seen;
                sentence.sentence_valid  = sentence.framing_ok && (xor_sum == hex_sum)
                                           && !overflowed;
                sentence.length_overflow = overflowed;
                sentence.computed_sum    = xor_sum;
                sentence.received_sum    = hex_sum;
                sentence.sentence_type   = TYPE_NONE;
                for (int i = 0; i < ID_COUNT; i++) begin
                    if (id_table[i] == id_bytes) begin
                        sentence.sentence_type = 3'(i);
                        break;
                    end
                end
                pending.push_back(sentence);
                clear_sentence();
            end

            // Every byte, the terminating LF included, goes into the buffer unless it is full.
            if (stored_count >= buffer_len) begin
                overflowed = 1'b1;
            end else begin
                stored_count++;
                if (star_seen && hex_count < 2) begin
                    hex_count++;
                    if (!hex_stopped) begin
                        if (b >= "0" && b <= "9") begin
                            digit = b - "0";
                        end else if (b >= "A" && b <= "F") begin
                            digit = b - "A" + 10;
                        end else if (b >= "a" && b <= "f") begin
                            digit = b - "a" + 10;
                        end else begin
                            digit = -1;
                        end
                        if (digit >= 0) begin
                            hex_sum = {hex_sum[3:0], 4'(digit)};
                        end else begin
                            hex_stopped = 1'b1;
                        end
                    end
                end
                if (start_seen && id_count < 5) begin
                    id_bytes[8 * (4 - id_count) +: 8] = b;
                    id_count++;
                end
                if (start_seen && !star_seen && b != CH_STAR) begin
                    xor_sum ^= b;
                end
                if (b == CH_STAR) begin
                    star_seen = 1'b1;
                end
                if (b == CH_START) begin
                    start_seen = 1'b1;
                end
            end
            last_was_cr = (b == CH_CR);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // Called for every result the block hands over.
        function void check_sentence(logic [23:0] tdata, logic [2:0] tuser);
            nmea_result_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected sentence result, expected none, actual tdata=%h tuser=%0d",
                         $time, tdata, tuser);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("sentence_valid",  want.sentence_valid,  tdata[0]);
            compare_field("framing_ok",      want.framing_ok,      tdata[1]);
            compare_field("length_overflow", want.length_overflow, tdata[2]);
            compare_field("computed_sum",    want.computed_sum,    tdata[10:3]);
            compare_field("received_sum",    want.received_sum,    tdata[18:11]);
            compare_field("sentence_type",   want.sentence_type,   tuser);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block inputs and the block itself.
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [0] sentence_valid, [1] framing_ok,
                                     // [2] length_overflow, [10:3] computed_sum,
                                     // [18:11] received_sum, [23:19] zero
    logic [2:0]  m_tuser;            // [2:0] sentence_type
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [39:0] cfg_data  = '0;

    sentence_scoreboard tracker;
    int unsigned        bytes_sent     = 0;
    int unsigned        src_idle_pct   = 0;
    int unsigned        sink_stall_pct = 0;

    nmea_sentence_checker #(
        .MAX_LEN (SENTENCE_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The consumer stalls at random; the stall rate changes between phases.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Every result taken by the consumer is checked in arrival order.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_sentence(m_tdata, m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Inputs change on the falling edge; a handshake is seen on the
    // rising edge, before the block's own registers update.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string text, input bit with_crlf);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i]);
        end
        if (with_crlf) begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    // ID registers are only written while the block is idle.
    task automatic program_id_word(input logic [2:0] index, input logic [ID_W-1:0] word);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= word;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_id_word(index, word);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every queued result, then let the pipeline
    // settle, since bytes that end no sentence leave nothing to wait for.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit lower);
        if (nibble < 10) begin
            return 8'h30 + 8'(nibble);
        end
        return (lower ? 8'h61 : 8'h41) + 8'(nibble) - 8'd10;
    endfunction

    // An ID close to the real talker IDs, so that random sentences hit the
    // table now and then.
    function automatic logic [ID_W-1:0] ascii_id();
        return {8'h47, 8'h50, 8'($urandom_range(8'h41, 8'h45)),
                8'($urandom_range(8'h41, 8'h45)), 8'($urandom_range(8'h41, 8'h45))};
    endfunction

    // One sentence: '$', an ID, filler, then mostly a correct checksum. A few
    // sentences lose the '*', carry a wrong sum, or have short or non-hex digits.
    task automatic send_random_sentence(input int unsigned filler_len);
        logic [7:0]      line[$];
        logic [7:0]      sum;
        logic [7:0]      b;
        logic [ID_W-1:0] id;
        int unsigned     id_len;
        int unsigned     style;
        sum = '0;
        line.push_back(CH_START);
        case ($urandom_range(3))
            0, 1:    id = tracker.id_table[$urandom_range(ID_COUNT - 1)];
            2:       id = ascii_id();
            default: id = ID_W'({$urandom, $urandom});
        endcase
        id_len = ($urandom_range(9) == 0) ? $urandom_range(4) : 5;
        for (int i = 0; i < id_len; i++) begin
            b = id[8 * (4 - i) +: 8];
            line.push_back(b);
            sum ^= b;
        end
        for (int i = 0; i < filler_len; i++) begin
            do b = 8'($urandom_range(255));
            while (b == CH_START || b == CH_STAR || b == CH_CR);
            line.push_back(b);
            sum ^= b;
        end
        style = $urandom_range(19);
        if (style != 0) begin
            line.push_back(CH_STAR);
        end
        case (style)
            0, 4: ;
            1: begin
                sum ^= 8'($urandom_range(1, 255));
                line.push_back(hex_char(sum[7:4], $urandom_range(1)));
                line.push_back(hex_char(sum[3:0], $urandom_range(1)));
            end
            2: begin
                line.push_back(hex_char(sum[7:4], $urandom_range(1)));
                line.push_back(8'($urandom_range(8'h67, 8'h7A)));
            end
            3: begin
                line.push_back(8'($urandom_range(8'h67, 8'h7A)));
                line.push_back(hex_char(sum[3:0], $urandom_range(1)));
            end
            default: begin
                line.push_back(hex_char(sum[7:4], $urandom_range(1)));
                line.push_back(hex_char(sum[3:0], $urandom_range(1)));
            end
        endcase
        line.push_back(CH_CR);
        line.push_back(CH_LF);
        foreach (line[i]) begin
            send_byte(line[i]);
        end
    endtask

    // A phase of traffic: optional buffer-sized sentences first, then mostly
    // short sentences with bursts of noise that favor the framing characters.
    task automatic run_traffic(input int unsigned budget, input int unsigned long_count);
        logic [7:0]  framing_chars[4];
        int unsigned phase_start;
        framing_chars = '{CH_START, CH_STAR, CH_CR, CH_LF};
        repeat (long_count) begin
            send_random_sentence($urandom_range(SENTENCE_MAX - 12, SENTENCE_MAX - 6));
        end
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < budget) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(3) == 0) begin
                        send_byte(framing_chars[$urandom_range(3)]);
                    end else begin
                        send_byte(8'($urandom_range(255)));
                    end
                end
            end else begin
                send_random_sentence($urandom_range(0, 12));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        tracker = new(SENTENCE_MAX);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase with a slow consumer, reset ID table.
        src_idle_pct   = 16;
        sink_stall_pct = 78;

        // Directed part: byte extremes, a lone LF, a CR followed by another
        // byte, a CR LF with no '$' before it, a valid GPRMC with a lowercase
        // digit, a sentence whose second digit is not hex, and one whose
        // first digit is not hex, both with a two-letter ID, so the '*' lands in the ID bytes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_text("A", 1'b1);
        send_text("$GPRMC*4b", 1'b1);
        send_text("$GP*cZ", 1'b1);
        send_text("$GP*", 1'b1);

        run_traffic(90, 0);
        wait_drained();

        // Talker-like IDs with the last one repeating the first, so the lower
        // index must win; a write past the table must change nothing.
        for (int i = 0; i < ID_COUNT - 1; i++) begin
            program_id_word(3'(i), ascii_id());
        end
        program_id_word(3'(ID_COUNT - 1), tracker.id_table[0]);
        program_id_word(REG_UNUSED, ascii_id());
        run_traffic(70, 1);
        wait_drained();

        // Slow sender from here on.
        src_idle_pct   = 78;
        sink_stall_pct = 16;

        // Extremes: an all-zero word, which matches sentences without '$',
        // and all-ones words at two indices.
        for (int i = 0; i < ID_COUNT; i++) begin
            program_id_word(3'(i), (i == 0) ? '0 :
                            ((i % 3 == 2) ? {ID_W{1'b1}} : tracker.id_table[i]));
        end
        run_traffic(70, 0);
        wait_drained();

        // Arbitrary 40-bit words.
        for (int i = 0; i < ID_COUNT; i++) begin
            program_id_word(3'(i), ID_W'({$urandom, $urandom}));
        end
        run_traffic(70, 0);
        wait_drained();

        // Neither side idles from here on.
        src_idle_pct   = 0;
        sink_stall_pct = 0;

        for (int i = 0; i < ID_COUNT; i++) begin
            program_id_word(3'(i), ID_RESET[i]);
        end
        program_id_word(REG_UNUSED, {ID_W{1'b1}});
        run_traffic(70, 1);
        wait_drained();

        for (int i = 0; i < ID_COUNT; i++) begin
            program_id_word(3'(i), {ID_W{1'b1}});
        end
        run_traffic(60, 0);
        wait_drained();

        if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
            $display("tb_nmea_sentence_checker: PASS");
        end else begin
            $display("tb_nmea_sentence_checker: FAIL");
        end
        $finish;
    end

    // Far beyond the slowest correct run: about a thousand bytes at the
    // heaviest idle rates.
    initial begin
        #5_000_000;
        $display("tb_nmea_sentence_checker: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/nmea_pkg.sv
rtl/nmea_front.sv
rtl/nmea_queue.sv
rtl/nmea_back.sv
rtl/nmea_sentence_checker.sv
tb/sv/tb_nmea_sentence_checker.sv
